FILE: rtl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and sizes for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

   localparam int DEPTH  = 32;                         // list capacity, 2..32
   localparam int IDX_W  = $clog2(DEPTH);              // cell index width
   localparam int CNT_W  = $clog2(DEPTH + 1);          // element count width
   localparam int CMP_W  = ((CNT_W > 6) ? CNT_W : 6) + 1;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_TRAVERSE = 2'd0,
      CMD_INSERT   = 2'd1,
      CMD_DELETE   = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // per-cycle operation broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] pos_idx;   // 0-based target position
      logic [IDX_W-1:0] last_idx;  // index of the last stored element
   } cell_ctrl_type;

endpackage

FILE: rtl/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell
// One list slot: holds a word and takes it from a neighbor on a shift, or loads the inserted value.
// ----------------------------------------------------------------------------
module pida_cell (
   input  logic                                clock,
   input  logic [pida_pkg::IDX_W-1:0]          cell_idx,
   input  pida_pkg::cell_ctrl_type             ctrl,
   input  logic signed [pida_pkg::DATA_W-1:0]  ins_value,
   input  logic signed [pida_pkg::DATA_W-1:0]  left_word,
   input  logic signed [pida_pkg::DATA_W-1:0]  right_word,
   input  logic signed [pida_pkg::DATA_W-1:0]  head_word,
   output logic signed [pida_pkg::DATA_W-1:0]  word
);

   logic signed [pida_pkg::DATA_W-1:0] word_ff;
   logic signed [pida_pkg::DATA_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         pida_pkg::CELL_INSERT: begin
            if (cell_idx > ctrl.pos_idx) begin
               word_in = left_word;
            end else if (cell_idx == ctrl.pos_idx) begin
               word_in = ins_value;
            end
         end
         pida_pkg::CELL_DELETE: begin
            if (cell_idx >= ctrl.pos_idx && cell_idx < ctrl.last_idx) begin
               word_in = right_word;
            end
         end
         pida_pkg::CELL_ROTATE: begin
            // head wraps around to the tail of the stored list
            if (cell_idx < ctrl.last_idx) begin
               word_in = right_word;
            end else if (cell_idx == ctrl.last_idx) begin
               word_in = head_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

FILE: rtl/positional_insert_delete_array_core.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array_core
// Ordered list of signed words with insert/delete at a 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells, cell 0 at the front. An insert,
// a delete, a bad request or an unused command is answered in the cycle
// after it is accepted: every cell shifts to its neighbor at once. A
// traverse answers with one result per stored element, one per cycle while
// the result side keeps up, or with a single result without an element for
// an empty list; no new request is taken until the walk ends. The elements
// are read from cell 0 while the chain rotates by one place per element,
// and after count steps the list is back in its original order. A new
// request is taken only when the output register is empty or its result
// leaves in the same cycle, so a stalled result holds off the next request.
// Entries are not cleared by reset; only positions below the count are ever
// read.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [5:0]                          req_position,
   input  logic signed [31:0]                  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_has_element,
   output logic signed [31:0]                  rsp_element,
   output logic [4:0]                          rsp_element_index,
   output logic [5:0]                          rsp_count_after,
   output logic                                rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TRAV = 2'b10
   } state_type;

   localparam int D = pida_pkg::DEPTH;
   localparam int IW = pida_pkg::IDX_W;
   localparam int CW = pida_pkg::CNT_W;
   localparam int MW = pida_pkg::CMP_W;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           trav_ff, trav_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic                    has_ff, has_in;
   logic signed [31:0]      elem_ff, elem_in;
   logic [4:0]              eidx_ff, eidx_in;
   logic [5:0]              cnt_out_ff, cnt_out_in;
   logic                    last_ff, last_in;

   pida_pkg::cell_ctrl_type ctrl;
   logic signed [31:0]      cell_word [D];

   logic                    slot_free;
   logic                    accept;
   logic [MW-1:0]           pos_w;
   logic [MW-1:0]           cnt_w;
   logic                    trav_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign pos_w     = MW'(req_position);
   assign cnt_w     = MW'(count_ff);
   assign trav_last = (CW'(trav_ff) == count_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      trav_in      = trav_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      has_in       = has_ff;
      elem_in      = elem_ff;
      eidx_in      = eidx_ff;
      cnt_out_in   = cnt_out_ff;
      last_in      = last_ff;

      ctrl.op       = pida_pkg::CELL_HOLD;
      ctrl.pos_idx  = IW'(req_position - 6'd1);
      ctrl.last_idx = IW'(count_ff - CW'(1));

      if (accept) begin
         // single-result requests: defaults for the answer
         rsp_valid_in = 1'b1;
         status_in    = pida_pkg::STATUS_OK;
         has_in       = 1'b0;
         elem_in      = '0;
         eidx_in      = '0;
         cnt_out_in   = 6'(count_ff);
         last_in      = 1'b1;
         case (pida_pkg::cmd_type'(req_command))
            pida_pkg::CMD_TRAVERSE: begin
               if (count_ff != '0) begin
                  // results come from the walk state
                  rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  status_in    = status_ff;
                  last_in      = last_ff;
                  cnt_out_in   = cnt_out_ff;
                  state_in     = ST_TRAV;
                  trav_in      = '0;
               end
            end
            pida_pkg::CMD_INSERT: begin
               if (pos_w == '0 || pos_w > cnt_w + MW'(1)) begin
                  status_in = pida_pkg::STATUS_BADPOS;
               end else if (count_ff == CW'(D)) begin
                  status_in = pida_pkg::STATUS_FULL;
               end else begin
                  ctrl.op    = pida_pkg::CELL_INSERT;
                  count_in   = count_ff + CW'(1);
                  cnt_out_in = 6'(count_ff + CW'(1));
               end
            end
            pida_pkg::CMD_DELETE: begin
               if (pos_w == '0 || pos_w > cnt_w) begin
                  status_in = pida_pkg::STATUS_BADPOS;
               end else begin
                  ctrl.op    = pida_pkg::CELL_DELETE;
                  count_in   = count_ff - CW'(1);
                  cnt_out_in = 6'(count_ff - CW'(1));
               end
            end
            default: begin
               status_in = pida_pkg::STATUS_OK;
            end
         endcase
      end else if (state_ff == ST_TRAV && slot_free) begin
         // emit the head element and rotate the list one place
         rsp_valid_in = 1'b1;
         status_in    = pida_pkg::STATUS_OK;
         has_in       = 1'b1;
         elem_in      = cell_word[0];
         eidx_in      = 5'(trav_ff);
         cnt_out_in   = 6'(count_ff);
         last_in      = trav_last;
         ctrl.op      = pida_pkg::CELL_ROTATE;
         trav_in      = trav_ff + IW'(1);
         if (trav_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         trav_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      has_ff     <= has_in;
      elem_ff    <= elem_in;
      eidx_ff    <= eidx_in;
      cnt_out_ff <= cnt_out_in;
      last_ff    <= last_in;
   end

   // cell chain: left neighbor feeds inserts, right neighbor deletes/rotates
   for (genvar g = 0; g < D; g++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = req_value;
      end else begin : g_mid
         assign left_w = cell_word[g-1];
      end
      if (g == D - 1) begin : g_tail
         assign right_w = cell_word[0];
      end else begin : g_inner
         assign right_w = cell_word[g+1];
      end
      pida_cell u_cell (
         .clock      (clock),
         .cell_idx   (IW'(g)),
         .ctrl       (ctrl),
         .ins_value  (req_value),
         .left_word  (left_w),
         .right_word (right_w),
         .head_word  (cell_word[0]),
         .word       (cell_word[g])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_has_element   = has_ff;
   assign rsp_element       = elem_ff;
   assign rsp_element_index = eidx_ff;
   assign rsp_count_after   = cnt_out_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/pida_checker.sv
// ----------------------------------------------------------------------------
// pida_checker
// Port-level checks for the positional insert/delete array.
// ----------------------------------------------------------------------------
module pida_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_command,
   input logic [5:0]         req_position,
   input logic signed [31:0] req_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic               rsp_has_element,
   input logic signed [31:0] rsp_element,
   input logic [4:0]         rsp_element_index,
   input logic [5:0]         rsp_count_after,
   input logic               rsp_last
);

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_command)
         && $stable(req_position) && $stable(req_value))
      else $error("request changed while waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_element) && $stable(rsp_count_after) && $stable(rsp_last))
      else $error("result changed while stalled");

   // an element only comes with an ok status
   a_elem_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_element |-> rsp_status == pida_pkg::STATUS_OK)
      else $error("element with error status");

   // a result without an element closes its request and carries zero
   a_noelem_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_element |-> rsp_last && rsp_element == '0
         && rsp_element_index == '0)
      else $error("empty result not final or not zero");

   // full is only reported when the list is at capacity
   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pida_pkg::STATUS_FULL
         |-> rsp_count_after == 6'(pida_pkg::DEPTH))
      else $error("full status below capacity");

endmodule

bind positional_insert_delete_array_core pida_checker u_pida_checker (.*);
